// File: rtl/vtp_pkg.sv
// vtp_pkg: shared widths, constants, register codes and word types
// for the vertex transform and projection unit; no dependencies
package vtp_pkg;

	localparam int FRAC_BITS = 16;
	localparam int IN_W      = 24;           // model coordinate width
	localparam int SC_W      = 24;           // scale register width
	localparam int TRIG_W    = 18;           // sine / cosine register width
	localparam int PIX_W     = 13;           // screen size register width
	localparam int SCR_W     = 19;           // screen coordinate width
	localparam int DEP_W     = 24;           // depth output width

	localparam int XW  = 33;                 // scaled coordinate
	localparam int RW  = 36;                 // rotated coordinate
	localparam int ZW  = 37;                 // depth after z shift
	localparam int DW  = 36;                 // divisor magnitude
	localparam int MW  = 37;                 // width times cos 30
	localparam int ML_W = 20;                // low part of projection factor
	localparam int MH_W = MW - ML_W;         // high part of projection factor
	localparam int NW  = 54;                 // numerator
	localparam int QW  = 21;                 // quotient bits (one per divider step)
	localparam int RMW = DW + 1;             // trial remainder

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	localparam logic [23:0] COS30_Q24 = 24'd14529495;
	localparam int NEAR_MAG = ((1 << FRAC_BITS) + 5) / 10;
	localparam logic [QW-1:0] QUOT_CAP = QW'(1 << 20);

	typedef enum logic [2:0] {
		REG_SCALE       = 3'd0,
		REG_COS_TILT    = 3'd1,
		REG_SIN_TILT    = 3'd2,
		REG_COS_SPIN    = 3'd3,
		REG_SIN_SPIN    = 3'd4,
		REG_SHIFT_DEPTH = 3'd5,
		REG_VIEW_WIDTH  = 3'd6,
		REG_VIEW_HEIGHT = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic        [SC_W-1:0]   scale;
		logic signed [TRIG_W-1:0] cos_tilt;
		logic signed [TRIG_W-1:0] sin_tilt;
		logic signed [TRIG_W-1:0] cos_spin;
		logic signed [TRIG_W-1:0] sin_spin;
		logic signed [IN_W-1:0]   shift_depth;
		logic        [PIX_W-1:0]  view_width;
		logic        [PIX_W-1:0]  view_height;
		logic        [MW-1:0]     proj_m;
	} cfg_t;

	// view-space vertex handed from the front to the back
	typedef struct packed {
		logic signed [RW-1:0]    vx;
		logic signed [RW-1:0]    vy;
		logic        [DW-1:0]    dmag;
		logic signed [DEP_W-1:0] depth;
		logic                    front;
		logic                    last;
	} vtx_t;

endpackage

// File: rtl/vertex_transform_project_unit.sv
// vertex_transform_project_unit: top level with configuration registers,
// front transform pipeline, vertex queue and projection back end; uses vtp_pkg
//
//   channel   dir  handshake                 payload
//   s_axis    in   s_axis_tvalid/tready      tdata pos_x, pos_y, pos_z; tlast
//   m_axis    out  m_axis_tvalid/tready      tdata px, py, depth; tuser; tlast
//   cfg       in   cfg_we                    cfg_index, cfg_data
//
// one vertex per clock sustained while m_axis_tready stays high; a word passes through the
// front stages, the queue and the back (multiply, add, 21 divider steps, output register)
// the queue holds 4 words so the front keeps accepting while the back stalls
// reset loads the default scale, rotation, z shift and 800 x 600 screen
// m_axis_tready low freezes the back; s_axis_tready drops while the queue is full and the last front stage holds a word
module vertex_transform_project_unit import vtp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,   // pos_x[23:0], pos_y[47:24], pos_z[71:48]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // screen_px[18:0], screen_py[37:19],
	                                    // depth_out[61:38], zero[63:62]
	output logic [0:0]  m_axis_tuser,   // in_front[0]
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	localparam logic signed [DEP_W-1:0] NEAR_NEG = DEP_W'(-NEAR_MAG);

	cfg_t cfg_q;
	logic push, pop, full, empty;
	vtx_t push_data, pop_data;
	logic signed [SCR_W-1:0] screen_px, screen_py;
	logic signed [DEP_W-1:0] depth_out;
	logic in_front, final_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale       <= SC_W'(1 << FRAC_BITS);
			cfg_q.cos_tilt    <= TRIG_W'(1 << FRAC_BITS);
			cfg_q.sin_tilt    <= '0;
			cfg_q.cos_spin    <= TRIG_W'(1 << FRAC_BITS);
			cfg_q.sin_spin    <= '0;
			cfg_q.shift_depth <= IN_W'(-5 * (1 << FRAC_BITS));
			cfg_q.view_width  <= PIX_W'(800);
			cfg_q.view_height <= PIX_W'(600);
			cfg_q.proj_m      <= MW'(800) * MW'(COS30_Q24);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SCALE:       cfg_q.scale       <= cfg_data[SC_W-1:0];
				REG_COS_TILT:    cfg_q.cos_tilt    <= cfg_data[TRIG_W-1:0];
				REG_SIN_TILT:    cfg_q.sin_tilt    <= cfg_data[TRIG_W-1:0];
				REG_COS_SPIN:    cfg_q.cos_spin    <= cfg_data[TRIG_W-1:0];
				REG_SIN_SPIN:    cfg_q.sin_spin    <= cfg_data[TRIG_W-1:0];
				REG_SHIFT_DEPTH: cfg_q.shift_depth <= cfg_data[IN_W-1:0];
				REG_VIEW_WIDTH: begin
					cfg_q.view_width <= cfg_data[PIX_W-1:0];
					// width times cos 30 kept ready for the divide
					cfg_q.proj_m <= MW'(cfg_data[PIX_W-1:0]) * MW'(COS30_Q24);
				end
				REG_VIEW_HEIGHT: cfg_q.view_height <= cfg_data[PIX_W-1:0];
			endcase
		end
	end

	vtp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.pos_x     (s_axis_tdata[23:0]),
		.pos_y     (s_axis_tdata[47:24]),
		.pos_z     (s_axis_tdata[71:48]),
		.in_last   (s_axis_tlast),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	vtp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (full),
		.empty     (empty)
	);

	vtp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.empty     (empty),
		.pop       (pop),
		.pop_data  (pop_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.screen_px (screen_px),
		.screen_py (screen_py),
		.depth_out (depth_out),
		.in_front  (in_front),
		.final_out (final_out)
	);

	assign m_axis_tdata = {2'b00, depth_out, screen_py, screen_px};
	assign m_axis_tuser = in_front;
	assign m_axis_tlast = final_out;

`ifndef SYNTHESIS
	a_front_depth: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && in_front |-> depth_out < NEAR_NEG)
		else $error("in_front word with depth at or behind the near limit");

	a_behind_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !in_front |-> depth_out == NEAR_NEG)
		else $error("word behind the near limit not clamped");

	a_width_factor: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && reg_idx_t'(cfg_index) == REG_VIEW_WIDTH
		|=> cfg_q.proj_m == MW'(cfg_q.view_width) * MW'(COS30_Q24))
		else $error("projection factor out of step with view width");

	a_queue_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && empty))
		else $error("queue overrun or underrun");
`endif

endmodule

// File: rtl/vtp_front.sv
// vtp_front: scale, two rotations, z shift and near-plane classification
// four pipeline stages; depends on vtp_pkg
module vtp_front import vtp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [IN_W-1:0] pos_x,
	input  logic signed [IN_W-1:0] pos_y,
	input  logic signed [IN_W-1:0] pos_z,
	input  logic                   in_last,
	input  logic                   full,
	output logic                   push,
	output vtx_t                   push_data
);

	localparam logic signed [ZW-1:0] NEAR_NEG = ZW'(-NEAR_MAG);

	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic last_s1, last_s2, last_s3;
	logic signed [XW-1:0] x_s1, y_s1, z_s1, x_s2;
	logic signed [RW-1:0] y1_s2, z1_s2, y1_s3, x2_s3, z2_s3;
	vtx_t vtx_s4;

	logic signed [IN_W+SC_W:0]   px_m, py_m, pz_m;
	logic signed [XW+TRIG_W:0]   y1_sum, z1_sum;
	logic signed [RW+TRIG_W:0]   x2_sum, z2_sum;
	logic signed [ZW-1:0]        zt, zc;
	logic                        front;
	logic signed [DEP_W-1:0]     depth_c;

	assign adv      = !(vld_s4 && full);
	assign in_ready = adv;
	assign push     = vld_s4 && !full;
	assign push_data = vtx_s4;

	assign px_m = pos_x * $signed({1'b0, cfg.scale});
	assign py_m = pos_y * $signed({1'b0, cfg.scale});
	assign pz_m = pos_z * $signed({1'b0, cfg.scale});

	assign y1_sum = y_s1 * cfg.cos_tilt - z_s1 * cfg.sin_tilt;
	assign z1_sum = y_s1 * cfg.sin_tilt + z_s1 * cfg.cos_tilt;

	assign x2_sum = x_s2 * cfg.cos_spin + z1_s2 * cfg.sin_spin;
	assign z2_sum = z1_s2 * cfg.cos_spin - x_s2 * cfg.sin_spin;

	assign zt    = ZW'(z2_s3) + ZW'(cfg.shift_depth);
	assign front = zt < NEAR_NEG;
	assign zc    = front ? zt : NEAR_NEG;

	// depth only ever saturates on the negative side
	always_comb begin
		if (zc[ZW-1:DEP_W-1] == '0 || zc[ZW-1:DEP_W-1] == '1) begin
			depth_c = zc[DEP_W-1:0];
		end else begin
			depth_c = {1'b1, {(DEP_W-1){1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1    <= XW'(px_m >>> FRAC_BITS);
			y_s1    <= XW'(py_m >>> FRAC_BITS);
			z_s1    <= XW'(pz_m >>> FRAC_BITS);
			last_s1 <= in_last;

			x_s2    <= x_s1;
			y1_s2   <= RW'(y1_sum >>> FRAC_BITS);
			z1_s2   <= RW'(z1_sum >>> FRAC_BITS);
			last_s2 <= last_s1;

			y1_s3   <= y1_s2;
			x2_s3   <= RW'(x2_sum >>> FRAC_BITS);
			z2_s3   <= RW'(z2_sum >>> FRAC_BITS);
			last_s3 <= last_s2;

			vtx_s4.vx    <= x2_s3;
			vtx_s4.vy    <= y1_s3;
			vtx_s4.dmag  <= DW'(-zc);
			vtx_s4.depth <= depth_c;
			vtx_s4.front <= front;
			vtx_s4.last  <= last_s3;
		end
	end

endmodule

// File: rtl/vtp_fifo.sv
// vtp_fifo: short queue of view-space vertices between front and back
// depends on vtp_pkg
module vtp_fifo import vtp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  vtx_t push_data,
	input  logic pop,
	output vtx_t pop_data,
	output logic full,
	output logic empty
);

	vtx_t            mem_q [QDEPTH];
	logic [QAW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QAW:0]    count_q;

	assign full     = count_q == (QAW+1)'(QDEPTH);
	assign empty    = count_q == '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

// File: rtl/vtp_back.sv
// vtp_back: perspective divide, one restoring step per stage, screen offset
// and saturation into the output register; depends on vtp_pkg
module vtp_back import vtp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     empty,
	output logic                     pop,
	input  vtx_t                     pop_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [SCR_W-1:0]  screen_px,
	output logic signed [SCR_W-1:0]  screen_py,
	output logic signed [DEP_W-1:0]  depth_out,
	output logic                     in_front,
	output logic                     final_out
);

	localparam int OW = QW + 2;

	typedef struct packed {
		logic [DW-1:0]           rx;
		logic [DW-1:0]           ry;
		logic [QW-1:0]           nx;
		logic [QW-1:0]           ny;
		logic [QW-1:0]           qx;
		logic [QW-1:0]           qy;
		logic                    ofx;
		logic                    ofy;
		logic                    sgx;
		logic                    sgy;
		logic [DW-1:0]           dmag;
		logic signed [DEP_W-1:0] depth;
		logic                    front;
		logic                    last;
	} div_t;

	function automatic logic signed [SCR_W-1:0] sat_scr(input logic signed [OW-1:0] v);
		if (v[OW-1:SCR_W-1] == '0 || v[OW-1:SCR_W-1] == '1) begin
			return v[SCR_W-1:0];
		end else if (v[OW-1]) begin
			return {1'b1, {(SCR_W-1){1'b0}}};
		end else begin
			return {1'b0, {(SCR_W-1){1'b1}}};
		end
	endfunction

	logic adv;
	logic ovld_q;
	logic vld_s1, vld_s2;
	logic [DW-1:0] ax, ay;
	logic [DW+MH_W-1:0] hx_s1, hy_s1;
	logic [DW+ML_W-1:0] lx_s1, ly_s1;
	logic sgx_s1, sgy_s1, sgx_s2, sgy_s2;
	logic [DW-1:0] dist_s1, dist_s2;
	logic signed [DEP_W-1:0] depth_s1, depth_s2;
	logic front_s1, front_s2, last_s1, last_s2;
	logic [NW-1:0] nx_s2, ny_s2;

	div_t seed;
	div_t div_s3 [QW];
	logic dvld_s3 [QW];

	div_t tail;
	logic [QW-1:0] qx_c, qy_c;
	logic signed [OW-1:0] offx, offy, sx, sy;

	logic signed [SCR_W-1:0] px_q, py_q;
	logic signed [DEP_W-1:0] depth_q;
	logic front_q, last_q;

	assign adv = !(ovld_q && !out_ready);
	assign pop = adv && !empty;

	assign ax = pop_data.vx[RW-1] ? DW'(-pop_data.vx) : DW'(pop_data.vx);
	assign ay = pop_data.vy[RW-1] ? DW'(-pop_data.vy) : DW'(pop_data.vy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= pop;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hx_s1    <= ax * cfg.proj_m[MW-1:ML_W];
			lx_s1    <= ax * cfg.proj_m[ML_W-1:0];
			hy_s1    <= ay * cfg.proj_m[MW-1:ML_W];
			ly_s1    <= ay * cfg.proj_m[ML_W-1:0];
			sgx_s1   <= pop_data.vx[RW-1];
			sgy_s1   <= pop_data.vy[RW-1];
			dist_s1  <= pop_data.dmag;
			depth_s1 <= pop_data.depth;
			front_s1 <= pop_data.front;
			last_s1  <= pop_data.last;

			nx_s2    <= NW'(hx_s1) + NW'(lx_s1 >> ML_W);
			ny_s2    <= NW'(hy_s1) + NW'(ly_s1 >> ML_W);
			sgx_s2   <= sgx_s1;
			sgy_s2   <= sgy_s1;
			dist_s2  <= dist_s1;
			depth_s2 <= depth_s1;
			front_s2 <= front_s1;
			last_s2  <= last_s1;
		end
	end

	// quotient above the top bit means the cap applies anyway
	always_comb begin
		seed       = '0;
		seed.rx    = DW'(nx_s2[NW-1:QW]);
		seed.ry    = DW'(ny_s2[NW-1:QW]);
		seed.nx    = nx_s2[QW-1:0];
		seed.ny    = ny_s2[QW-1:0];
		seed.ofx   = DW'(nx_s2[NW-1:QW]) >= dist_s2;
		seed.ofy   = DW'(ny_s2[NW-1:QW]) >= dist_s2;
		seed.sgx   = sgx_s2;
		seed.sgy   = sgy_s2;
		seed.dmag  = dist_s2;
		seed.depth = depth_s2;
		seed.front = front_s2;
		seed.last  = last_s2;
	end

	for (genvar j = 0; j < QW; j++) begin : g_step
		div_t cur, nxt;
		logic vcur;
		logic [RMW-1:0] tx, ty;
		logic gx, gy;

		if (j == 0) begin : g_head
			assign cur  = seed;
			assign vcur = vld_s2;
		end else begin : g_tail
			assign cur  = div_s3[j-1];
			assign vcur = dvld_s3[j-1];
		end

		assign tx = {cur.rx, cur.nx[QW-1]};
		assign ty = {cur.ry, cur.ny[QW-1]};
		assign gx = tx >= RMW'(cur.dmag);
		assign gy = ty >= RMW'(cur.dmag);

		always_comb begin
			nxt    = cur;
			nxt.rx = gx ? DW'(tx - RMW'(cur.dmag)) : DW'(tx);
			nxt.ry = gy ? DW'(ty - RMW'(cur.dmag)) : DW'(ty);
			nxt.nx = cur.nx << 1;
			nxt.ny = cur.ny << 1;
			nxt.qx = {cur.qx[QW-2:0], gx};
			nxt.qy = {cur.qy[QW-2:0], gy};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvld_s3[j] <= 1'b0;
			end else if (adv) begin
				dvld_s3[j] <= vcur;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) div_s3[j] <= nxt;
		end
	end

	assign tail = div_s3[QW-1];
	assign qx_c = (tail.ofx || tail.qx > QUOT_CAP) ? QUOT_CAP : tail.qx;
	assign qy_c = (tail.ofy || tail.qy > QUOT_CAP) ? QUOT_CAP : tail.qy;
	assign offx = $signed(OW'({cfg.view_width, 3'b000}));
	assign offy = $signed(OW'({cfg.view_height, 3'b000}));
	assign sx   = tail.sgx ? offx - $signed(OW'(qx_c)) : offx + $signed(OW'(qx_c));
	// screen y grows downward
	assign sy   = tail.sgy ? offy + $signed(OW'(qy_c)) : offy - $signed(OW'(qy_c));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (adv) begin
			ovld_q <= dvld_s3[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_q    <= sat_scr(sx);
			py_q    <= sat_scr(sy);
			depth_q <= tail.depth;
			front_q <= tail.front;
			last_q  <= tail.last;
		end
	end

	assign out_valid = ovld_q;
	assign screen_px = px_q;
	assign screen_py = py_q;
	assign depth_out = depth_q;
	assign in_front  = front_q;
	assign final_out = last_q;

endmodule
